// ===== src/alm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alm_pkg: audio level meter shared definitions
// Field widths, datapath widths, register codes, FSM and control types.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int WIN_W      = 16;
  localparam int SUM_W      = 33;
  localparam int SQ_W       = 46;
  localparam int MAC_W      = 64;
  localparam int MUL_W      = 32;
  localparam int MAC_CNT_W  = 5;
  localparam int DC_W       = 20;
  localparam int RMS_W      = 20;
  localparam int DIV_W      = MUL_W + 4;
  localparam int DIV_CNT_W  = 6;
  localparam int RAD_W      = 70;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SQRT_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 2'd1;

  localparam logic [CFG_W-1:0]    WINDOW_RST = 16'd16000;
  localparam logic [CFG_W-1:0]    SETTLE_RST = 16'd8000;
  localparam logic [SAMPLE_W-1:0] CLIP_LEVEL = 16'd32767;

  localparam logic [MAC_CNT_W-1:0] SQ_LAST  = MAC_CNT_W'(SAMPLE_W - 1);
  localparam logic [MAC_CNT_W-1:0] MUL_LAST = MAC_CNT_W'(WIN_W - 1);
  localparam logic [MAC_CNT_W-1:0] SUB_LAST = MAC_CNT_W'(MUL_W - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_ACC,
    ST_DC_GO,
    ST_DC_WAIT,
    ST_MUL,
    ST_SUB,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_RMS_GO,
    ST_RMS_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    MAC_SQ,
    MAC_MUL,
    MAC_SUB
  } mac_op_e;

  typedef struct packed {
    logic    take;
    logic    settle_dec;
    logic    mac_ld;
    mac_op_e mac_op;
    logic    mac_run;
    logic    mac_sub;
    logic    acc_upd;
    logic    div_start;
    logic    div_sel_rms;
    logic    dc_cap;
    logic    sq_start;
    logic    out_load;
  } ctrl_t;

  function automatic logic [SAMPLE_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] s);
    return s[SAMPLE_W-1] ? (~s + 1'b1) : s;
  endfunction

endpackage
`default_nettype wire

// ===== src/audio_level_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// audio_level_meter: windowed DC / RMS / peak / clip meter for 16-bit PCM
// Input channel: in_valid_i, in_stall_o, sample_i; one sample per beat.
// Output channel: out_valid_o, out_stall_i and the five result fields; one
// beat per finished window.
// Config: cfg_we_i, cfg_index_i, cfg_wdata_i; index 0 window length, index 1
// settle count (also reloads the settle counter). Write only while idle.
// After reset the first settle samples are dropped.
// An ordinary sample is accepted, squared bit-serially, then accumulated.
// A window-ending sample then runs a 36-step serial divide for DC, a
// 48-step serial multiply/subtract for the variance, a 35-step serial
// root and a second 36-step divide for RMS.
// The result sits in an output register; while the receiver stalls, a
// further window-ending sample waits in the last step with the input stalled.
// Reset: window 16000, settle 8000, accumulators and window counter cleared.
// ----------------------------------------------------------------------------
module audio_level_meter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [alm_pkg::SAMPLE_W-1:0]  sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [alm_pkg::WIN_W-1:0]     window_index_o,
  output logic [alm_pkg::DC_W-1:0]      dc_q4_o,
  output logic [alm_pkg::RMS_W-1:0]     rms_q4_o,
  output logic [alm_pkg::SAMPLE_W-1:0]  peak_o,
  output logic [alm_pkg::WIN_W-1:0]     clip_count_o,
  input  logic                          cfg_we_i,
  input  logic [alm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [alm_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import alm_pkg::*;

  state_e state_q, state_d;
  ctrl_t  ctl;

  logic [CFG_W-1:0]     window_q;
  logic [CFG_W-1:0]     settle_left_q;
  logic [SUM_W-1:0]     acc_sum_q;
  logic [SQ_W-1:0]      acc_sq_q;
  logic [SAMPLE_W-1:0]  peak_q;
  logic [WIN_W-1:0]     clip_q;
  logic [WIN_W-1:0]     cnt_win_q;
  logic [WIN_W-1:0]     win_done_q;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [MAC_W-1:0]     mcand_q;
  logic [MUL_W-1:0]     mplier_q;
  logic [MAC_W-1:0]     mac_acc_q, mac_acc_d;
  logic [MAC_CNT_W-1:0] mac_cnt_q;
  logic [DC_W-1:0]      dc_q;

  logic                 out_valid_q;
  logic [WIN_W-1:0]     out_idx_q;
  logic [DC_W-1:0]      out_dc_q;
  logic [RMS_W-1:0]     out_rms_q;
  logic [SAMPLE_W-1:0]  out_peak_q;
  logic [WIN_W-1:0]     out_clip_q;

  logic                 in_acc;
  logic                 out_free;
  logic                 mac_last;
  logic                 win_end;
  logic [CFG_W-1:0]     wlen;
  logic [SAMPLE_W-1:0]  a_in;
  logic [SAMPLE_W-1:0]  a_cur;
  logic [SUM_W-1:0]     sum_abs_w;
  logic [MUL_W-1:0]     sum_abs;
  logic [DIV_W-1:0]     div_dividend;
  logic [DIV_W-1:0]     div_quot;
  logic                 div_done;
  logic [RAD_W-1:0]     radicand;
  logic [ROOT_W-1:0]    root;
  logic                 sq_done;
  logic [DC_W-1:0]      q_dc;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign mac_last = (mac_cnt_q == '0);
  assign wlen     = (window_q == '0) ? CFG_W'(1) : window_q;
  assign win_end  = ({1'b0, cnt_win_q} + 1'b1) >= {1'b0, wlen};
  assign a_in     = abs_sample(sample_i);
  assign a_cur    = abs_sample(sample_q);
  assign sum_abs_w = acc_sum_q[SUM_W-1] ? (~acc_sum_q + 1'b1) : acc_sum_q;
  assign sum_abs   = sum_abs_w[MUL_W-1:0];
  assign q_dc      = div_quot[DC_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && settle_left_q == '0) begin
          state_d = ST_SQR;
        end
      end
      ST_SQR:       if (mac_last) state_d = ST_ACC;
      ST_ACC:       state_d = win_end ? ST_DC_GO : ST_IDLE;
      ST_DC_GO:     state_d = ST_DC_WAIT;
      ST_DC_WAIT:   if (div_done) state_d = ST_MUL;
      ST_MUL:       if (mac_last) state_d = ST_SUB;
      ST_SUB:       if (mac_last) state_d = ST_SQRT_GO;
      ST_SQRT_GO:   state_d = ST_SQRT_WAIT;
      ST_SQRT_WAIT: if (sq_done) state_d = ST_RMS_GO;
      ST_RMS_GO:    state_d = ST_RMS_WAIT;
      ST_RMS_WAIT:  if (div_done) state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.take = 1'b1;
          if (settle_left_q != '0) begin
            ctl.settle_dec = 1'b1;
          end else begin
            ctl.mac_ld = 1'b1;
            ctl.mac_op = MAC_SQ;
          end
        end
      end
      ST_SQR: ctl.mac_run = 1'b1;
      ST_ACC: ctl.acc_upd = 1'b1;
      ST_DC_GO: ctl.div_start = 1'b1;
      ST_DC_WAIT: begin
        if (div_done) begin
          ctl.dc_cap = 1'b1;
          ctl.mac_ld = 1'b1;
          ctl.mac_op = MAC_MUL;
        end
      end
      ST_MUL: begin
        ctl.mac_run = 1'b1;
        if (mac_last) begin
          ctl.mac_ld = 1'b1;
          ctl.mac_op = MAC_SUB;
        end
      end
      ST_SUB: begin
        ctl.mac_run = 1'b1;
        ctl.mac_sub = 1'b1;
      end
      ST_SQRT_GO: ctl.sq_start = 1'b1;
      ST_SQRT_WAIT: ctl = '0;
      ST_RMS_GO: begin
        ctl.div_start   = 1'b1;
        ctl.div_sel_rms = 1'b1;
      end
      ST_RMS_WAIT: ctl = '0;
      ST_OUT: ctl.out_load = out_free;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q      <= WINDOW_RST;
      settle_left_q <= SETTLE_RST;
      acc_sum_q     <= '0;
      acc_sq_q      <= '0;
      peak_q        <= '0;
      clip_q        <= '0;
      cnt_win_q     <= '0;
      win_done_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_WINDOW) begin
        window_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_SETTLE) begin
        settle_left_q <= cfg_wdata_i;
      end else if (ctl.settle_dec) begin
        settle_left_q <= settle_left_q - 1'b1;
      end
      if (ctl.acc_upd) begin
        acc_sum_q <= acc_sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
        acc_sq_q  <= acc_sq_q + mac_acc_q[SQ_W-1:0];
        cnt_win_q <= cnt_win_q + 1'b1;
        if (a_cur > peak_q) begin
          peak_q <= a_cur;
        end
        if (a_cur >= CLIP_LEVEL) begin
          clip_q <= clip_q + 1'b1;
        end
      end else if (ctl.out_load) begin
        acc_sum_q  <= '0;
        acc_sq_q   <= '0;
        peak_q     <= '0;
        clip_q     <= '0;
        cnt_win_q  <= '0;
        win_done_q <= win_done_q + 1'b1;
      end
    end
  end

  // bit-serial multiply / multiply-subtract
  always_comb begin
    mac_acc_d = mac_acc_q;
    if (mplier_q[0]) begin
      mac_acc_d = ctl.mac_sub ? (mac_acc_q - mcand_q) : (mac_acc_q + mcand_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.take) begin
      sample_q <= sample_i;
    end
    if (ctl.mac_ld) begin
      unique case (ctl.mac_op)
        MAC_SQ: begin
          mcand_q   <= {{(MAC_W-SAMPLE_W){1'b0}}, a_in};
          mplier_q  <= {{(MUL_W-SAMPLE_W){1'b0}}, a_in};
          mac_cnt_q <= SQ_LAST;
        end
        MAC_MUL: begin
          mcand_q   <= {{(MAC_W-SQ_W){1'b0}}, acc_sq_q};
          mplier_q  <= {{(MUL_W-WIN_W){1'b0}}, cnt_win_q};
          mac_cnt_q <= MUL_LAST;
        end
        MAC_SUB: begin
          mcand_q   <= {{(MAC_W-MUL_W){1'b0}}, sum_abs};
          mplier_q  <= sum_abs;
          mac_cnt_q <= SUB_LAST;
        end
        default: begin
          mcand_q   <= '0;
          mplier_q  <= '0;
          mac_cnt_q <= '0;
        end
      endcase
    end else if (ctl.mac_run) begin
      mcand_q   <= {mcand_q[MAC_W-2:0], 1'b0};
      mplier_q  <= {1'b0, mplier_q[MUL_W-1:1]};
      mac_cnt_q <= mac_cnt_q - 1'b1;
    end
    if (ctl.mac_run) begin
      mac_acc_q <= mac_acc_d;
    end else if (ctl.mac_ld && ctl.mac_op != MAC_SUB) begin
      mac_acc_q <= '0;
    end
    if (ctl.dc_cap) begin
      dc_q <= acc_sum_q[SUM_W-1] ? (~q_dc + 1'b1) : q_dc;
    end
  end

  // divide and root units
  assign div_dividend = ctl.div_sel_rms ? {{(DIV_W-ROOT_W){1'b0}}, root}
                      : ({sum_abs, 4'b0000}
                         + {{(DIV_W-WIN_W+1){1'b0}}, cnt_win_q[WIN_W-1:1]});

  assign radicand = mac_acc_q[MAC_W-1] ? '0 : {mac_acc_q[RAD_W-9:0], 8'h00};

  alm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_win_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  alm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.sq_start),
    .radicand_i (radicand),
    .done_o     (sq_done),
    .root_o     (root)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      out_idx_q  <= win_done_q + 1'b1;
      out_dc_q   <= dc_q;
      out_rms_q  <= div_quot[RMS_W-1:0];
      out_peak_q <= peak_q;
      out_clip_q <= clip_q;
    end
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign window_index_o = out_idx_q;
  assign dc_q4_o        = out_dc_q;
  assign rms_q4_o       = out_rms_q;
  assign peak_o         = out_peak_q;
  assign clip_count_o   = out_clip_q;

`ifndef NO_ASSERTIONS
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DC_WAIT || state_q == ST_RMS_WAIT))
    else $error("divider finished outside a divide wait");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == ST_SQRT_WAIT))
    else $error("root unit finished outside its wait");

  a_window_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DC_GO) |-> (cnt_win_q != '0))
    else $error("window closed with zero samples");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |=> (out_valid_q && state_q == ST_IDLE && cnt_win_q == '0))
    else $error("result beat not presented after window close");
`endif

endmodule
`default_nettype wire

// ===== src/alm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alm_div: serial restoring divider
// One quotient bit per cycle; done pulses once the quotient is final.
// ----------------------------------------------------------------------------
module alm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [alm_pkg::DIV_W-1:0]  dividend_i,
  input  logic [alm_pkg::WIN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [alm_pkg::DIV_W-1:0]  quot_o
);
  import alm_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [WIN_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q;
  logic [WIN_W-1:0]     dvs_q;
  logic [WIN_W:0]       trial;
  logic [WIN_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? diff[WIN_W-1:0] : trial[WIN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule
`default_nettype wire

// ===== src/alm_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alm_sqrt: serial integer square root
// Two radicand bits per cycle, one root bit per cycle; floor result.
// ----------------------------------------------------------------------------
module alm_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alm_pkg::RAD_W-1:0]   radicand_i,
  output logic                        done_o,
  output logic [alm_pkg::ROOT_W-1:0]  root_o
);
  import alm_pkg::*;

  logic                  busy_q;
  logic                  done_q;
  logic [SQRT_CNT_W-1:0] cnt_q;
  logic [RAD_W-1:0]      rad_q;
  logic [ROOT_W-1:0]     root_q, root_d;
  logic [ROOT_W:0]       rem_q, rem_d;
  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     test;
  logic [ROOT_W+2:0]     diff;
  logic                  ge;

  always_comb begin
    trial  = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
    test   = {1'b0, root_q, 2'b01};
    diff   = trial - test;
    ge     = trial >= test;
    rem_d  = ge ? diff[ROOT_W:0] : trial[ROOT_W:0];
    root_d = {root_q[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= SQRT_CNT_W'(ROOT_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the audio level meter
// A scripted run covers full-scale and clipping samples, settle skipping,
// unmapped register writes, window-length extremes and a mid-window settle
// reload. Random phases then vary window and settle lengths between runs of
// mixed or DC-biased audio. The sender works in bursts and the receiver
// stalls on its own schedule. Every result beat is checked field by field
// against scripted expectations or an in-bench level predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import alm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_B = 2'd3;
  localparam int                   RANDOM_ITEMS   = 650;

  typedef struct packed {
    logic [WIN_W-1:0]       window_index;
    logic [DC_W-1:0]        dc_q4;
    logic [RMS_W-1:0]       rms_q4;
    logic [SAMPLE_W-1:0]    peak;
    logic [WIN_W-1:0]       clip_count;
  } level_t;

  typedef enum bit {STEP_WRITE, STEP_SAMPLE} step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       wdata;
    logic [SAMPLE_W-1:0]    smp;
    bit                     typed;
    level_t                 lvl;
  } step_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WIN_W-1:0]     window_index;
  logic [DC_W-1:0]      dc_q4;
  logic [RMS_W-1:0]     rms_q4;
  logic [SAMPLE_W-1:0]  peak;
  logic [WIN_W-1:0]     clip_count;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // predictor state
  logic [CFG_W-1:0]     win_len;
  logic [CFG_W-1:0]     settle_len;
  logic [CFG_W-1:0]     settle_left;
  logic signed [SUM_W-1:0] sum_acc;
  logic [SQ_W-1:0]      sq_acc;
  logic [SAMPLE_W-1:0]  peak_hold;
  logic [WIN_W-1:0]     clip_hold;
  logic [WIN_W-1:0]     win_fill;
  logic [WIN_W-1:0]     wins_done;

  level_t               pending_levels[$];
  int                   mismatch_count = 0;
  int                   measured_items = 0;
  int                   burst_left = 1;
  bit                   pipe_busy = 1'b0;
  int unsigned          stall_hold = 0;

  step_t script [36] = '{
    '{STEP_WRITE,  CFG_SETTLE,     16'd2,      16'd0,        1'b0, '0},
    '{STEP_WRITE,  CFG_WINDOW,     16'd1,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd1000,     1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      -16'sd1000,   1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h7FFF,     1'b1,
      '{16'd1, 20'sd524272, 20'd0, 16'd32767, 16'd1}},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h8000,     1'b1,
      '{16'd2, 20'h80000, 20'd0, 16'h8000, 16'd1}},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd0,        1'b1,
      '{16'd3, 20'd0, 20'd0, 16'd0, 16'd0}},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'hFFFF,     1'b1,
      '{16'd4, -20'sd16, 20'd0, 16'd1, 16'd0}},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h8001,     1'b1,
      '{16'd5, -20'sd524272, 20'd0, 16'd32767, 16'd1}},
    '{STEP_WRITE,  CFG_UNMAPPED_A, 16'd7,      16'd0,        1'b0, '0},
    '{STEP_WRITE,  CFG_UNMAPPED_B, 16'hFFFF,   16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd1,        1'b1,
      '{16'd6, 20'sd16, 20'd0, 16'd1, 16'd0}},
    '{STEP_WRITE,  CFG_WINDOW,     16'd4,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h7FFF,     1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h8000,     1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd1,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'hFFFF,     1'b0, '0},
    '{STEP_WRITE,  CFG_WINDOW,     16'hFFFF,   16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd12345,    1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      -16'sd23456,  1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd7,        1'b0, '0},
    '{STEP_WRITE,  CFG_SETTLE,     16'hFFFF,   16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd30000,    1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      -16'sd30000,  1'b0, '0},
    '{STEP_WRITE,  CFG_SETTLE,     16'd0,      16'd0,        1'b0, '0},
    '{STEP_WRITE,  CFG_WINDOW,     16'd0,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      -16'sd5,      1'b0, '0},
    '{STEP_WRITE,  CFG_WINDOW,     16'd3,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd100,      1'b0, '0},
    '{STEP_WRITE,  CFG_SETTLE,     16'd1,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd20000,    1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'd200,      1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      -16'sd300,    1'b0, '0},
    '{STEP_WRITE,  CFG_WINDOW,     16'd2,      16'd0,        1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h8000,     1'b0, '0},
    '{STEP_SAMPLE, CFG_WINDOW,     16'd0,      16'h7FFF,     1'b0, '0}
  };

  audio_level_meter dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .window_index_o (window_index),
    .dc_q4_o        (dc_q4),
    .rms_q4_o       (rms_q4),
    .peak_o         (peak),
    .clip_count_o   (clip_count),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic meter_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    case (idx)
      CFG_WINDOW: win_len = d;
      CFG_SETTLE: begin
        settle_len  = d;
        settle_left = d;
      end
      default: ;
    endcase
  endtask

  task automatic meter_predict(input logic [SAMPLE_W-1:0] s, output bit got,
                               output level_t r);
    int          v;
    logic [16:0] mag;
    longint      sum64;
    logic [63:0] n, sum_abs, q, nsq, ssq, var_n;
    logic [71:0] rad, root, trial, quo;
    longint      dc64;
    got = 1'b0;
    r   = '0;
    if (settle_left != 0) begin
      settle_left--;
      return;
    end
    measured_items++;
    v   = $signed(s);
    mag = (v < 0) ? 17'(-v) : 17'(v);
    sum_acc   = sum_acc + SUM_W'(v);
    sq_acc    = sq_acc + SQ_W'(mag) * SQ_W'(mag);
    if (mag > 17'(peak_hold)) peak_hold = mag[15:0];
    if (mag >= 17'(CLIP_LEVEL)) clip_hold++;
    win_fill++;
    if (win_fill < ((win_len == 0) ? 16'd1 : win_len)) return;

    n       = 64'(win_fill);
    sum64   = sum_acc;
    sum_abs = (sum64 < 0) ? 64'(-sum64) : 64'(sum64);
    q       = (16 * sum_abs + n / 2) / n;
    dc64    = (sum64 < 0) ? -longint'(q) : longint'(q);
    nsq     = n * 64'(sq_acc);
    ssq     = sum_abs * sum_abs;
    var_n   = (nsq > ssq) ? nsq - ssq : 64'd0;
    // floor(16*sqrt(var)) as integer root of 256*var
    rad  = {var_n, 8'h00};
    root = '0;
    for (int i = 35; i >= 0; i--) begin
      trial = root | (72'd1 << i);
      if (trial * trial <= rad) root = trial;
    end
    quo = root / 72'(n);
    wins_done++;
    r.window_index = wins_done;
    r.dc_q4        = dc64[DC_W-1:0];
    r.rms_q4       = quo[RMS_W-1:0];
    r.peak         = peak_hold;
    r.clip_count   = clip_hold;
    got            = 1'b1;
    sum_acc   = '0;
    sq_acc    = '0;
    peak_hold = '0;
    clip_hold = '0;
    win_fill  = '0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    meter_write(idx, d);
    @(posedge clk);
  endtask

  task automatic drive_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input level_t want);
    level_t guess;
    bit     got;
    in_valid <= 1'b1;
    sample   <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    meter_predict(s, got, guess);
    if (typed) pending_levels.push_back(want);
    else if (got) pending_levels.push_back(guess);
    pipe_busy = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3))
        @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(1, 8);
    end
  endtask

  // drain results, then let a non-window beat finish before touching registers
  task automatic wait_quiet();
    if (!pipe_busy) return;
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    pipe_busy = 1'b0;
  endtask

  always @(posedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          out_stall  <= 1'b0;
          stall_hold <= $urandom_range(20, 200);
        end
        1: begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(1, 300);
        end
        default: begin
          out_stall  <= 1'($urandom_range(0, 1));
          stall_hold <= $urandom_range(0, 4);
        end
      endcase
    end
  end

  always @(posedge clk) begin : result_mon
    level_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_levels.size() == 0) begin
        flag_error($sformatf("unexpected result beat, window_index %0d", window_index));
      end else begin
        want = pending_levels.pop_front();
        if (window_index !== want.window_index)
          flag_error($sformatf("window_index got %0d exp %0d",
                               window_index, want.window_index));
        if (dc_q4 !== want.dc_q4)
          flag_error($sformatf("dc_q4 got %0d exp %0d (window %0d)",
                               $signed(dc_q4), $signed(want.dc_q4), want.window_index));
        if (rms_q4 !== want.rms_q4)
          flag_error($sformatf("rms_q4 got %0d exp %0d (window %0d)",
                               rms_q4, want.rms_q4, want.window_index));
        if (peak !== want.peak)
          flag_error($sformatf("peak got %0d exp %0d (window %0d)",
                               peak, want.peak, want.window_index));
        if (clip_count !== want.clip_count)
          flag_error($sformatf("clip_count got %0d exp %0d (window %0d)",
                               clip_count, want.clip_count, want.window_index));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int                   start_count;
    int                   style;
    logic [SAMPLE_W-1:0]  base;
    logic [SAMPLE_W-1:0]  s;
    logic [CFG_IDX_W-1:0] spare;

    win_len     = WINDOW_RST;
    settle_len  = SETTLE_RST;
    settle_left = SETTLE_RST;
    sum_acc     = '0;
    sq_acc      = '0;
    peak_hold   = '0;
    clip_hold   = '0;
    win_fill    = '0;
    wins_done   = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        wait_quiet();
        write_reg(script[i].idx, script[i].wdata);
      end else begin
        drive_sample(script[i].smp, script[i].typed, script[i].lvl);
      end
    end

    start_count = measured_items;
    while (measured_items - start_count < RANDOM_ITEMS) begin
      wait_quiet();
      case ($urandom_range(0, 9))
        0:       write_reg(CFG_WINDOW, CFG_W'($urandom_range(0, 1)));
        7, 8:    write_reg(CFG_WINDOW, CFG_W'($urandom_range(9, 40)));
        9:       write_reg(CFG_WINDOW, CFG_W'($urandom_range(100, 200)));
        default: write_reg(CFG_WINDOW, CFG_W'($urandom_range(2, 8)));
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SETTLE, CFG_W'($urandom_range(0, 6)));
      if ($urandom_range(0, 7) == 0) begin
        spare = ($urandom_range(0, 1) == 0) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B;
        write_reg(spare, CFG_W'($urandom));
      end
      style = $urandom_range(0, 2);
      base  = SAMPLE_W'($urandom);
      repeat ($urandom_range(10, 60)) begin
        case ($urandom_range(0, 9))
          0:       s = 16'h7FFF;
          1:       s = 16'h8000;
          2:       s = 16'h8001;
          3:       s = SAMPLE_W'($urandom_range(0, 8)) - 16'd4;
          default: s = SAMPLE_W'($urandom);
        endcase
        // DC-heavy phase: small noise around a fixed level
        if (style == 0) s = base + SAMPLE_W'($urandom_range(0, 15));
        drive_sample(s, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
